FILE: sv/fat_chain_table_engine_core_defines.svh
// assertion macros shared by the chain table engine checkers
// expects clk and rst_n to be visible where a macro is used
`ifndef FAT_CHAIN_TABLE_ENGINE_CORE_DEFINES_SVH
`define FAT_CHAIN_TABLE_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define FCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/fct_pkg.sv
// shared types and constants for the chain table engine
// no dependencies
package fct_pkg;

    localparam int unsigned FCT_TABLE_DEPTH = 1024;

    localparam int unsigned CMD_W   = 2;
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned STEP_W  = 11;
    localparam int unsigned VAL_W   = 16;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned LIMIT_W = 11;
    // wide enough for any link value and any table depth
    localparam int unsigned CMP_W   = 17;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
    localparam logic [VAL_W-1:0]   END_MARK    = 16'hFFFF;
    localparam logic [VAL_W-1:0]   FREE_MARK   = 16'h0000;
    localparam int unsigned        FIRST_ALLOC = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FOLLOW = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFREE = 2'd1;
    localparam logic [STAT_W-1:0] ST_END    = 2'd2;

    // datapath actions issued by the controller
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_CLEAR,
        ACT_LOAD,
        ACT_ALLOC_STEP,
        ACT_ALLOC_TAKE,
        ACT_ALLOC_FAIL,
        ACT_FOLLOW_STEP,
        ACT_FOLLOW_END,
        ACT_FOLLOW_OK,
        ACT_WRITE,
        ACT_NOP_RESULT
    } act_t;

    typedef struct packed {
        logic clear_last;
        logic alloc_hit;
        logic alloc_end;
        logic follow_zero;
        logic follow_bad;
    } dp_stat_t;

endpackage

FILE: sv/fct_if.sv
// request and response channel interfaces of the chain table engine
// depends on fct_pkg
interface fct_req_if import fct_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [IDX_W-1:0]   block_index;
    logic [STEP_W-1:0]  step_count;
    logic [VAL_W-1:0]   entry_value;

    modport source (output valid, cmd, block_index, step_count, entry_value, input ready);
    modport sink   (input valid, cmd, block_index, step_count, entry_value, output ready);
endinterface

interface fct_rsp_if import fct_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VAL_W-1:0]   result_block;
    logic [STAT_W-1:0]  status;

    modport source (output valid, result_block, status, input ready);
    modport sink   (input valid, result_block, status, output ready);
endinterface

FILE: sv/fct_ctrl.sv
// controller state machine of the chain table engine
// depends on fct_pkg; drives the datapath through act_t and reads dp_stat_t
module fct_ctrl import fct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [CMD_W-1:0] in_cmd,
    output logic             in_ready,
    input  logic             out_ready,
    output logic             out_valid,
    input  dp_stat_t         stat,
    output act_t             act
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_FOLLOW,
        S_WRITE,
        S_NOP
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;
    logic   finish;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        act        = ACT_NONE;
        finish     = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                act = ACT_CLEAR;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act = ACT_LOAD;
                    case (in_cmd)
                        CMD_ALLOC:  state_next = S_ALLOC;
                        CMD_FOLLOW: state_next = S_FOLLOW;
                        CMD_WRITE:  state_next = S_WRITE;
                        default:    state_next = S_NOP;
                    endcase
                end
            end
            S_ALLOC:
            begin
                // a hit or the end of the range waits here for a free output slot
                if (stat.alloc_hit)
                begin
                    if (slot_free)
                    begin
                        act        = ACT_ALLOC_TAKE;
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.alloc_end)
                begin
                    if (slot_free)
                    begin
                        act        = ACT_ALLOC_FAIL;
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    act = ACT_ALLOC_STEP;
                end
            end
            S_FOLLOW:
            begin
                if (stat.follow_zero)
                begin
                    if (slot_free)
                    begin
                        act        = ACT_FOLLOW_OK;
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.follow_bad)
                begin
                    if (slot_free)
                    begin
                        act        = ACT_FOLLOW_END;
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    act = ACT_FOLLOW_STEP;
                end
            end
            S_WRITE:
            begin
                if (slot_free)
                begin
                    act        = ACT_WRITE;
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_NOP:
            begin
                if (slot_free)
                begin
                    act        = ACT_NOP_RESULT;
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = finish ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/fct_datapath.sv
// datapath of the chain table engine: link table ram, scan and walk registers, result register
// depends on fct_pkg; controlled by fct_ctrl through act_t
module fct_datapath import fct_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = FCT_TABLE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    input  logic [IDX_W-1:0]   in_block_index,
    input  logic [STEP_W-1:0]  in_step_count,
    input  logic [VAL_W-1:0]   in_entry_value,
    input  act_t               act,
    output dp_stat_t           stat,
    output logic [VAL_W-1:0]   result_block,
    output logic [STAT_W-1:0]  status
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);

    logic [VAL_W-1:0] mem [TABLE_DEPTH];
    logic [VAL_W-1:0] rd_data_reg;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [CW-1:0]      scan_reg, scan_next;
    logic               chk_valid_reg, chk_valid_next;
    logic               use_rd_reg, use_rd_next;
    logic [AW-1:0]      chk_idx_reg, chk_idx_next;
    logic [VAL_W-1:0]   cur_reg, cur_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [VAL_W-1:0]   value_reg, value_next;
    logic [VAL_W-1:0]   result_block_reg, result_block_next;
    logic [STAT_W-1:0]  status_reg, status_next;

    logic [CMP_W-1:0] lim;
    logic [CMP_W-1:0] idx_ext;
    logic [VAL_W-1:0] cur_val;

    // the scan stops at the smaller of the configured limit and the table size
    assign lim = (CMP_W'(limit_reg) > DEPTH_C) ? DEPTH_C : CMP_W'(limit_reg);
    assign idx_ext = CMP_W'(idx_reg);
    // once a step has been issued the current block comes straight from the ram
    assign cur_val = use_rd_reg ? rd_data_reg : cur_reg;

    assign stat.clear_last  = (scan_reg == CW'(TABLE_DEPTH - 1));
    assign stat.alloc_hit   = chk_valid_reg && (rd_data_reg == FREE_MARK);
    assign stat.alloc_end   = (CMP_W'(scan_reg) >= lim);
    assign stat.follow_zero = (steps_reg == '0);
    assign stat.follow_bad  = (cur_val == END_MARK) || (CMP_W'(cur_val) >= DEPTH_C);

    assign result_block = result_block_reg;
    assign status       = status_reg;

    always_comb
    begin
        limit_next        = cfg_we ? cfg_wdata : limit_reg;
        scan_next         = scan_reg;
        chk_valid_next    = chk_valid_reg;
        use_rd_next       = use_rd_reg;
        chk_idx_next      = chk_idx_reg;
        cur_next          = cur_reg;
        steps_next        = steps_reg;
        idx_next          = idx_reg;
        value_next        = value_reg;
        result_block_next = result_block_reg;
        status_next       = status_reg;
        mem_we            = 1'b0;
        mem_waddr         = scan_reg[AW-1:0];
        mem_wdata         = FREE_MARK;
        mem_re            = 1'b0;
        mem_raddr         = scan_reg[AW-1:0];
        case (act)
            ACT_CLEAR:
            begin
                mem_we    = 1'b1;
                scan_next = scan_reg + 1'b1;
            end
            ACT_LOAD:
            begin
                scan_next      = CW'(FIRST_ALLOC);
                chk_valid_next = 1'b0;
                use_rd_next    = 1'b0;
                cur_next       = VAL_W'(in_block_index);
                steps_next     = in_step_count;
                idx_next       = in_block_index;
                value_next     = in_entry_value;
            end
            ACT_ALLOC_STEP:
            begin
                mem_re         = 1'b1;
                chk_idx_next   = scan_reg[AW-1:0];
                chk_valid_next = 1'b1;
                scan_next      = scan_reg + 1'b1;
            end
            ACT_ALLOC_TAKE:
            begin
                mem_we            = 1'b1;
                mem_waddr         = chk_idx_reg;
                mem_wdata         = END_MARK;
                result_block_next = VAL_W'(chk_idx_reg);
                status_next       = ST_OK;
            end
            ACT_ALLOC_FAIL:
            begin
                result_block_next = '0;
                status_next       = ST_NOFREE;
            end
            ACT_FOLLOW_STEP:
            begin
                mem_re      = 1'b1;
                mem_raddr   = cur_val[AW-1:0];
                steps_next  = steps_reg - 1'b1;
                use_rd_next = 1'b1;
            end
            ACT_FOLLOW_END:
            begin
                result_block_next = END_MARK;
                status_next       = ST_END;
            end
            ACT_FOLLOW_OK:
            begin
                result_block_next = cur_val;
                status_next       = ST_OK;
            end
            ACT_WRITE:
            begin
                // an index past the table leaves it untouched
                mem_we            = (idx_ext < DEPTH_C);
                mem_waddr         = idx_ext[AW-1:0];
                mem_wdata         = value_reg;
                result_block_next = VAL_W'(idx_reg);
                status_next       = ST_OK;
            end
            ACT_NOP_RESULT:
            begin
                result_block_next = '0;
                status_next       = ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            scan_reg      <= '0;
            chk_valid_reg <= 1'b0;
            use_rd_reg    <= 1'b0;
        end
        else
        begin
            limit_reg     <= limit_next;
            scan_reg      <= scan_next;
            chk_valid_reg <= chk_valid_next;
            use_rd_reg    <= use_rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg      <= chk_idx_next;
        cur_reg          <= cur_next;
        steps_reg        <= steps_next;
        idx_reg          <= idx_next;
        value_reg        <= value_next;
        result_block_reg <= result_block_next;
        status_reg       <= status_next;
    end

endmodule

FILE: sv/fat_chain_table_engine_core.sv
// After reset the engine clears its link table RAM to all free and takes no request
// in that time; the alloc_limit register may be written then as ever. One request is
// worked on at a time. Follow walks one link per cycle, set by the single read port of
// the table RAM, and stops early when the chain ends. Allocate visits one entry per
// cycle from index 2 up to, not including, min(alloc_limit, TABLE_DEPTH) and fails
// when none of those is free. A finished result sits in the output register until
// taken while the next request is accepted.
// depends on fct_pkg, fct_if, fct_ctrl and fct_datapath
module fat_chain_table_engine_core import fct_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = FCT_TABLE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    fct_req_if.sink            req,
    fct_rsp_if.source          rsp
);

    act_t     act;
    dp_stat_t stat;

    fct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_cmd    (req.cmd),
        .in_ready  (req.ready),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .stat      (stat),
        .act       (act)
    );

    fct_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_block_index (req.block_index),
        .in_step_count  (req.step_count),
        .in_entry_value (req.entry_value),
        .act            (act),
        .stat           (stat),
        .result_block   (rsp.result_block),
        .status         (rsp.status)
    );

endmodule

FILE: sv/fct_checker.sv
// port-level checker for the chain table engine and its bind to the top level
// depends on fct_pkg and fat_chain_table_engine_core_defines.svh
`include "fat_chain_table_engine_core_defines.svh"

module fct_checker import fct_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [VAL_W-1:0]  rsp_result_block,
    input logic [STAT_W-1:0] rsp_status
);

    `FCT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_block) && $stable(rsp_status), "response changed while stalled")
    `FCT_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while another is at work")
    `FCT_ASSERT_NOW(a_status_code, rsp_valid, (rsp_status == ST_OK) || (rsp_status == ST_NOFREE) || (rsp_status == ST_END), "unknown status code")
    `FCT_ASSERT_NOW(a_nofree_zero, rsp_valid && (rsp_status == ST_NOFREE), rsp_result_block == '0, "failed allocation with nonzero block")
    `FCT_ASSERT_NOW(a_end_mark, rsp_valid && (rsp_status == ST_END), rsp_result_block == END_MARK, "early end without end mark")

endmodule

bind fat_chain_table_engine_core fct_checker u_fct_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_result_block (rsp.result_block),
    .rsp_status       (rsp.status)
);

FILE: sim/tb_top.sv
// self-checking testbench for fat_chain_table_engine_core: directed table, then random phases
// depends on fct_pkg, fct_req_if, fct_rsp_if and the engine rtl
module tb_top;
    import fct_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam int unsigned      RUN_ITEMS   = 580;
    localparam int unsigned      TAIL_ITEMS  = 60;
    localparam int unsigned      MAX_SHOWN   = 10;
    localparam int unsigned      CYCLE_LIMIT = 3000000;

    typedef enum logic {ROW_REQ, ROW_LIMIT} row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [CMD_W-1:0]    cmd;
        logic [IDX_W-1:0]    blk;
        logic [STEP_W-1:0]   steps;
        logic [VAL_W-1:0]    val;
        logic                known;
        logic [VAL_W-1:0]    exp_blk;
        logic [STAT_W-1:0]   exp_st;
        logic [LIMIT_W-1:0]  limit;
    } stim_row_t;

    typedef struct packed {
        logic [VAL_W-1:0]  blk;
        logic [STAT_W-1:0] st;
    } chain_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;

    fct_req_if req_ch ();
    fct_rsp_if rsp_ch ();

    fat_chain_table_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // shadow copy of the link table and the allocation limit
    logic [VAL_W-1:0]   link_shadow [FCT_TABLE_DEPTH];
    logic [LIMIT_W-1:0] limit_shadow;

    chain_result_t awaited_results [$];
    int unsigned   error_count;
    int unsigned   sent_count;
    int unsigned   cycle_count;
    int unsigned   req_calm;
    bit            tail_mode;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL fat_chain_table_engine_core");
            $finish;
        end
    end

    function automatic stim_row_t req_row(logic [CMD_W-1:0] c, logic [IDX_W-1:0] b,
                                          logic [STEP_W-1:0] s, logic [VAL_W-1:0] v);
        stim_row_t r;
        r       = '0;
        r.kind  = ROW_REQ;
        r.cmd   = c;
        r.blk   = b;
        r.steps = s;
        r.val   = v;
        return r;
    endfunction

    function automatic stim_row_t chk_row(logic [CMD_W-1:0] c, logic [IDX_W-1:0] b,
                                          logic [STEP_W-1:0] s, logic [VAL_W-1:0] v,
                                          logic [VAL_W-1:0] eb, logic [STAT_W-1:0] es);
        stim_row_t r;
        r         = req_row(c, b, s, v);
        r.known   = 1'b1;
        r.exp_blk = eb;
        r.exp_st  = es;
        return r;
    endfunction

    function automatic stim_row_t lim_row(logic [LIMIT_W-1:0] l);
        stim_row_t r;
        r       = '0;
        r.kind  = ROW_LIMIT;
        r.limit = l;
        return r;
    endfunction

    // applies one command to the shadow table and returns the outcome
    function automatic chain_result_t chain_table_outcome(stim_row_t r);
        chain_result_t    res;
        int unsigned      top;
        logic [VAL_W-1:0] cur;
        res.blk = '0;
        res.st  = ST_OK;
        case (r.cmd)
            CMD_ALLOC:
            begin
                top    = (limit_shadow > FCT_TABLE_DEPTH) ? FCT_TABLE_DEPTH : limit_shadow;
                res.st = ST_NOFREE;
                for (int unsigned i = FIRST_ALLOC; i < top; i++)
                begin
                    if (link_shadow[i] == FREE_MARK)
                    begin
                        link_shadow[i] = END_MARK;
                        res.blk        = VAL_W'(i);
                        res.st         = ST_OK;
                        break;
                    end
                end
            end
            CMD_FOLLOW:
            begin
                cur = VAL_W'(r.blk);
                for (int unsigned n = 0; n < r.steps; n++)
                begin
                    // end mark or a link past the table stops the walk early
                    if (cur == END_MARK || cur >= FCT_TABLE_DEPTH)
                    begin
                        res.st = ST_END;
                        break;
                    end
                    cur = link_shadow[cur[IDX_W-1:0]];
                end
                res.blk = (res.st == ST_END) ? END_MARK : cur;
            end
            CMD_WRITE:
            begin
                link_shadow[r.blk] = r.val;
                res.blk            = VAL_W'(r.blk);
            end
            default:
            begin
                res.blk = '0;
            end
        endcase
        return res;
    endfunction

    task automatic maybe_gap();
        int unsigned len;
        if (tail_mode)
            return;
        if (req_calm > 0)
        begin
            req_calm--;
            return;
        end
        if ($urandom_range(0, 2) == 0)
        begin
            len = $urandom_range(1, 19);
            req_ch.valid <= 1'b0;
            repeat (len) @(posedge clk);
        end
        else
        begin
            req_calm = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
        end
    endtask

    task automatic send_req(stim_row_t r);
        chain_result_t res;
        maybe_gap();
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= r.cmd;
        req_ch.block_index <= r.blk;
        req_ch.step_count  <= r.steps;
        req_ch.entry_value <= r.val;
        do
            @(posedge clk);
        while (!req_ch.ready);
        res = chain_table_outcome(r);
        if (r.known)
        begin
            res.blk = r.exp_blk;
            res.st  = r.exp_st;
        end
        awaited_results.push_back(res);
        sent_count++;
    endtask

    // limit changes only once every pending transaction has come back
    task automatic set_limit(logic [LIMIT_W-1:0] l);
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= l;
        @(posedge clk);
        cfg_we       <= 1'b0;
        limit_shadow  = l;
    endtask

    task automatic run_row(stim_row_t r);
        if (r.kind == ROW_LIMIT)
            set_limit(r.limit);
        else
            send_req(r);
    endtask

    task automatic flag_mismatch(string what, chain_result_t want);
        error_count++;
        if (error_count <= MAX_SHOWN)
            $display("mismatch: %s, expected block %h status %0d, got block %h status %0d",
                     what, want.blk, want.st, rsp_ch.result_block, rsp_ch.status);
    endtask

    always @(posedge clk)
    begin : check_rsp
        chain_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                want = '0;
                flag_mismatch("result with nothing pending", want);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (rsp_ch.result_block !== want.blk || rsp_ch.status !== want.st)
                    flag_mismatch("wrong result", want);
            end
        end
    end

    initial
    begin : rsp_pacing
        int unsigned len;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            if (!tail_mode && $urandom_range(0, 2) == 0)
            begin
                len = $urandom_range(1, 19);
                rsp_ch.ready <= 1'b0;
                repeat (len) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            if (tail_mode)
                len = 1;
            else if ($urandom_range(0, 7) == 0)
                len = $urandom_range(50, 200);
            else
                len = $urandom_range(1, 30);
            repeat (len) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        stim_row_t          directed [$];
        int unsigned        phase_end;
        int unsigned        hop_count;
        int unsigned        mix;
        logic [IDX_W-1:0]   hops [8];
        logic [VAL_W-1:0]   last_link;
        logic [LIMIT_W-1:0] phase_limit;
        logic [STEP_W-1:0]  walk;

        error_count  = 0;
        sent_count   = 0;
        cycle_count  = 0;
        req_calm     = 0;
        tail_mode    = 1'b0;
        limit_shadow = LIMIT_RESET;
        foreach (link_shadow[i])
            link_shadow[i] = FREE_MARK;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.cmd         <= '0;
        req_ch.block_index <= '0;
        req_ch.step_count  <= '0;
        req_ch.entry_value <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // zero steps, then a free entry read as a link
        directed.push_back(chk_row(CMD_FOLLOW, 10'd5, 11'd0, 16'h0000, 16'd5, ST_OK));
        directed.push_back(chk_row(CMD_FOLLOW, 10'd5, 11'd1, 16'h0000, 16'd0, ST_OK));
        directed.push_back(chk_row(CMD_ALLOC, 10'd0, 11'd0, 16'h0000, 16'd2, ST_OK));
        directed.push_back(chk_row(CMD_ALLOC, 10'd0, 11'd0, 16'h0000, 16'd3, ST_OK));
        directed.push_back(chk_row(CMD_WRITE, 10'd3, 11'd0, 16'h0000, 16'd3, ST_OK));
        directed.push_back(chk_row(CMD_ALLOC, 10'd0, 11'd0, 16'h0000, 16'd3, ST_OK));
        // end mark on the last step is fine, one step more is not
        directed.push_back(chk_row(CMD_WRITE, 10'd1023, 11'd1024, END_MARK, 16'd1023, ST_OK));
        directed.push_back(chk_row(CMD_FOLLOW, 10'd1023, 11'd1, 16'h0000, END_MARK, ST_OK));
        directed.push_back(chk_row(CMD_FOLLOW, 10'd1023, 11'd2, 16'h0000, END_MARK, ST_END));
        directed.push_back(req_row(CMD_WRITE, 10'd10, 11'd0, 16'd11));
        directed.push_back(req_row(CMD_WRITE, 10'd11, 11'd0, 16'd12));
        directed.push_back(req_row(CMD_WRITE, 10'd12, 11'd0, END_MARK));
        directed.push_back(req_row(CMD_FOLLOW, 10'd10, 11'd2, 16'h0000));
        directed.push_back(chk_row(CMD_FOLLOW, 10'd10, 11'd1024, 16'h0000, END_MARK, ST_END));
        // link that points past the table
        directed.push_back(req_row(CMD_WRITE, 10'd20, 11'd0, 16'h0400));
        directed.push_back(chk_row(CMD_FOLLOW, 10'd20, 11'd2, 16'h0000, END_MARK, ST_END));
        directed.push_back(req_row(CMD_WRITE, 10'h155, 11'h2AA, 16'h5555));
        directed.push_back(chk_row(CMD_UNUSED, 10'h2AA, 11'h155, 16'hAAAA, 16'd0, ST_OK));
        directed.push_back(lim_row(11'd3));
        directed.push_back(chk_row(CMD_ALLOC, 10'd0, 11'd0, 16'h0000, 16'd0, ST_NOFREE));
        directed.push_back(chk_row(CMD_WRITE, 10'd2, 11'd0, FREE_MARK, 16'd2, ST_OK));
        directed.push_back(chk_row(CMD_ALLOC, 10'd0, 11'd0, 16'h0000, 16'd2, ST_OK));
        directed.push_back(lim_row(11'd0));
        directed.push_back(chk_row(CMD_ALLOC, 10'd0, 11'd0, 16'h0000, 16'd0, ST_NOFREE));
        directed.push_back(lim_row(11'd2047));
        directed.push_back(req_row(CMD_ALLOC, 10'd0, 11'd0, 16'h0000));
        foreach (directed[n])
            run_row(directed[n]);

        while (sent_count < RUN_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0:       phase_limit = 11'd3;
                1:       phase_limit = 11'd2047;
                2:       phase_limit = LIMIT_W'($urandom_range(0, 2));
                3:       phase_limit = LIMIT_W'($urandom_range(3, 40));
                4, 5:    phase_limit = LIMIT_W'($urandom_range(3, 1024));
                default: phase_limit = LIMIT_RESET;
            endcase
            run_row(lim_row(phase_limit));
            phase_end = sent_count + $urandom_range(40, 90);
            while (sent_count < phase_end && sent_count < RUN_ITEMS)
            begin
                tail_mode = (sent_count + TAIL_ITEMS >= RUN_ITEMS);
                mix       = $urandom_range(0, 99);
                if (mix < 45)
                begin
                    // build a short chain, then walk it
                    hop_count = $urandom_range(2, 6);
                    for (int unsigned j = 0; j < hop_count; j++)
                        hops[j] = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(0, 1023))
                                                               : IDX_W'($urandom_range(0, 127));
                    for (int unsigned j = 0; j + 1 < hop_count; j++)
                        run_row(req_row(CMD_WRITE, hops[j], '0, VAL_W'(hops[j+1])));
                    case ($urandom_range(0, 9))
                        0:       last_link = VAL_W'($urandom_range(1024, 65534));
                        1:       last_link = FREE_MARK;
                        2:       last_link = VAL_W'($urandom_range(0, 1023));
                        default: last_link = END_MARK;
                    endcase
                    run_row(req_row(CMD_WRITE, hops[hop_count-1], '0, last_link));
                    repeat ($urandom_range(1, 2))
                    begin
                        walk = ($urandom_range(0, 29) == 0) ? 11'd1024
                                                            : STEP_W'($urandom_range(0, hop_count + 1));
                        run_row(req_row(CMD_FOLLOW, hops[0], walk, VAL_W'($urandom_range(0, 65535))));
                    end
                end
                else if (mix < 65)
                begin
                    if ($urandom_range(0, 2) == 0)
                        run_row(req_row(CMD_WRITE, IDX_W'($urandom_range(2, 127)), '0, FREE_MARK));
                    repeat ($urandom_range(1, 4))
                        run_row(req_row(CMD_ALLOC, IDX_W'($urandom_range(0, 1023)),
                                        STEP_W'($urandom_range(0, 1024)), VAL_W'($urandom_range(0, 65535))));
                end
                else if (mix < 80)
                begin
                    run_row(req_row(CMD_FOLLOW,
                                    ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 1023))
                                                                : IDX_W'($urandom_range(0, 127)),
                                    STEP_W'($urandom_range(0, 8)), VAL_W'($urandom_range(0, 65535))));
                end
                else
                begin
                    walk = ($urandom_range(0, 9) == 0) ? STEP_W'($urandom_range(0, 1024))
                                                       : STEP_W'($urandom_range(0, 16));
                    run_row(req_row(CMD_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 1023)),
                                    walk, VAL_W'($urandom_range(0, 65535))));
                end
            end
        end

        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (error_count == 0 && awaited_results.size() == 0)
            $display("PASS fat_chain_table_engine_core");
        else
            $display("FAIL fat_chain_table_engine_core");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/fct_pkg.sv
sv/fct_if.sv
sv/fct_ctrl.sv
sv/fct_datapath.sv
sv/fat_chain_table_engine_core.sv
sv/fct_checker.sv
sim/tb_top.sv
